[design/tprc_pkg.sv]
// ----------------------------------------------------------------------------
// Timer prescaler/reload calculator package
// Shared codes, constants and unit request types.
// ----------------------------------------------------------------------------
package tprc_pkg;

  typedef logic [1:0] mode_t;
  typedef logic [1:0] status_t;

  localparam mode_t MODE_FREQ   = 2'd0;
  localparam mode_t MODE_PERIOD = 2'd1;
  localparam mode_t MODE_DUTY   = 2'd2;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_ZERO  = 2'd1;
  localparam status_t ST_RANGE = 2'd2;

  localparam logic [31:0] CLOCK_HZ_RESET = 32'd16000000;
  localparam logic [31:0] RELOAD_SPAN    = 32'd65536;
  localparam logic [31:0] PERMIL_FULL    = 32'd1000;
  localparam logic [31:0] US_PER_SECOND  = 32'd1000000;

  localparam logic [6:0] DIV_STEPS_SHORT = 7'd32;
  localparam logic [6:0] DIV_STEPS_LONG  = 7'd64;
  localparam logic [5:0] MUL_STEPS       = 6'd32;

  typedef struct packed {
    logic        start;
    logic        wide;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

endpackage

[design/tprc_if.sv]
// ----------------------------------------------------------------------------
// Timer prescaler/reload calculator channels
// Valid/ready channels for the request word and the result word.
// ----------------------------------------------------------------------------
interface tprc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [31:0] value;
  logic [2:0]  channel;

  modport source (output valid, mode, value, channel, input ready);
  modport sink (input valid, mode, value, channel, output ready);
endinterface

interface tprc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] prescaler;
  logic [15:0] reload;
  logic [15:0] compare;
  logic [2:0]  out_channel;
  logic [1:0]  status;

  modport source (output valid, prescaler, reload, compare, out_channel, status,
                  input ready);
  modport sink (input valid, prescaler, reload, compare, out_channel, status,
                output ready);
endinterface

[design/tprc_mul.sv]
// ----------------------------------------------------------------------------
// Serial multiplier
// 32 x 32 shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module tprc_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  tprc_pkg::mul_req_t req,
  output logic               done,
  output logic [63:0]        product
);

  logic [5:0]  cnt_r;
  logic        done_r;
  logic [31:0] a_r;
  logic [63:0] p_r;
  logic [32:0] sum;

  assign sum = {1'b0, p_r[63:32]} + {1'b0, (p_r[0] ? a_r : 32'd0)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= tprc_pkg::MUL_STEPS;
      end else if (cnt_r != 6'd0) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
      p_r <= {32'd0, req.b};
    end else if (cnt_r != 6'd0) begin
      p_r <= {sum, p_r[31:1]};
    end
  end

  assign done    = done_r;
  assign product = p_r;

endmodule

[design/tprc_div.sv]
// ----------------------------------------------------------------------------
// Serial divider
// Restoring divider, one quotient bit per cycle, 32- or 64-bit dividend.
// ----------------------------------------------------------------------------
module tprc_div (
  input  logic               clk,
  input  logic               rst_n,
  input  tprc_pkg::div_req_t req,
  output logic               done,
  output logic [63:0]        quotient
);

  logic [6:0]  cnt_r;
  logic        done_r;
  logic [63:0] sh_r;
  logic [31:0] rem_r;
  logic [31:0] dvs_r;
  logic [32:0] rem_shift;
  logic [33:0] diff;
  logic        qbit;
  logic [31:0] rem_nxt;

  assign rem_shift = {rem_r, sh_r[63]};
  assign diff      = {1'b0, rem_shift} - {2'b00, dvs_r};
  assign qbit      = !diff[33];
  assign rem_nxt   = qbit ? diff[31:0] : rem_shift[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        cnt_r <= req.wide ? tprc_pkg::DIV_STEPS_LONG : tprc_pkg::DIV_STEPS_SHORT;
      end else if (cnt_r != 7'd0) begin
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      sh_r  <= req.wide ? req.dividend : {req.dividend[31:0], 32'd0};
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (cnt_r != 7'd0) begin
      sh_r  <= {sh_r[62:0], qbit};
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = sh_r;

endmodule

[design/timer_prescaler_reload_calc.sv]
// Throughput: one word at a time; the next word is taken in the cycle after the result loads.
// A finished result waits in the output register while the next word is taken.
// Reset (synchronous, rst_n low): clock_hz to 16000000, stored reload to 0, channels empty.
// ----------------------------------------------------------------------------
// Timer prescaler/reload calculator
// Sequences a serial multiplier and a serial divider to work out prescaler,
// reload and compare values from the peripheral clock.
// ----------------------------------------------------------------------------
module timer_prescaler_reload_calc (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  tprc_in_if.sink     in_ch,
  tprc_out_if.source  out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV_Q,
    S_DIV_T,
    S_DIV_C,
    S_SPLIT,
    S_DIV_R,
    S_DONE
  } state_t;

  state_t                state_r;
  tprc_pkg::mode_t       mode_r;
  logic [2:0]            chan_r;
  logic [31:0]           clk_hz_r;
  logic [15:0]           reload_r;
  logic [31:0]           tot_r;
  logic [16:0]           psc_r;
  logic                  freq_r;
  logic                  bump_r;
  tprc_pkg::div_req_t    div_req_r;
  tprc_pkg::mul_req_t    mul_req_r;

  logic [15:0]           res_psc_r;
  logic [15:0]           res_arr_r;
  logic [15:0]           res_cmp_r;
  logic [2:0]            res_och_r;
  tprc_pkg::status_t     res_st_r;

  logic                  out_valid_r;
  logic [15:0]           out_psc_r;
  logic [15:0]           out_arr_r;
  logic [15:0]           out_cmp_r;
  logic [2:0]            out_och_r;
  tprc_pkg::status_t     out_st_r;

  logic                  div_done;
  logic [63:0]           div_q;
  logic                  mul_done;
  logic [63:0]           mul_p;
  logic [31:0]           q32;
  logic [31:0]           q32_dec;
  logic [31:0]           tot_dec;
  logic [15:0]           split_p;
  logic [16:0]           split_div;
  logic [31:0]           permil;
  logic                  r_bad;

  tprc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req_r),
    .done     (div_done),
    .quotient (div_q)
  );

  tprc_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mul_req_r),
    .done    (mul_done),
    .product (mul_p)
  );

  assign q32       = div_q[31:0];
  assign q32_dec   = q32 - 32'd1;
  assign tot_dec   = tot_r - 32'd1;
  assign split_p   = freq_r ? tot_dec[31:16] : tot_r[31:16];
  assign split_div = {1'b0, split_p} + 17'd1;
  assign permil    = (in_ch.value > tprc_pkg::PERMIL_FULL) ? tprc_pkg::PERMIL_FULL
                                                           : in_ch.value;
  assign r_bad     = (q32 == 32'd0) || (q32 > tprc_pkg::RELOAD_SPAN);

  assign in_ch.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clk_hz_r    <= tprc_pkg::CLOCK_HZ_RESET;
      reload_r    <= '0;
      div_req_r   <= '0;
      mul_req_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      div_req_r.start <= 1'b0;
      mul_req_r.start <= 1'b0;
      if (cfg_we) begin
        clk_hz_r <= cfg_wdata;
      end
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            mode_r    <= in_ch.mode;
            chan_r    <= in_ch.channel;
            res_psc_r <= '0;
            res_arr_r <= '0;
            res_cmp_r <= '0;
            res_och_r <= '0;
            res_st_r  <= tprc_pkg::ST_OK;
            case (in_ch.mode)
              tprc_pkg::MODE_FREQ: begin
                if (in_ch.value == 32'd0) begin
                  res_st_r <= tprc_pkg::ST_ZERO;
                  state_r  <= S_DONE;
                end else begin
                  div_req_r <= '{start: 1'b1, wide: 1'b0,
                                 dividend: {32'd0, clk_hz_r}, divisor: in_ch.value};
                  state_r   <= S_DIV_Q;
                end
              end
              tprc_pkg::MODE_PERIOD: begin
                mul_req_r <= '{start: 1'b1, a: clk_hz_r, b: in_ch.value};
                state_r   <= S_MUL;
              end
              tprc_pkg::MODE_DUTY: begin
                mul_req_r <= '{start: 1'b1, a: {16'd0, reload_r}, b: permil};
                state_r   <= S_MUL;
              end
              default: begin
                res_st_r <= tprc_pkg::ST_RANGE;
                state_r  <= S_DONE;
              end
            endcase
          end
        end
        S_MUL: begin
          if (mul_done) begin
            if (mode_r == tprc_pkg::MODE_PERIOD) begin
              div_req_r <= '{start: 1'b1, wide: 1'b1, dividend: mul_p,
                             divisor: tprc_pkg::US_PER_SECOND};
              state_r   <= S_DIV_T;
            end else begin
              div_req_r <= '{start: 1'b1, wide: 1'b0, dividend: {32'd0, mul_p[31:0]},
                             divisor: tprc_pkg::PERMIL_FULL};
              state_r   <= S_DIV_C;
            end
          end
        end
        S_DIV_Q: begin
          if (div_done) begin
            tot_r   <= q32;
            freq_r  <= 1'b1;
            bump_r  <= 1'b0;
            state_r <= S_SPLIT;
          end
        end
        S_DIV_T: begin
          if (div_done) begin
            if (div_q[63:32] != 32'd0) begin
              res_st_r <= tprc_pkg::ST_RANGE;
              state_r  <= S_DONE;
            end else begin
              tot_r   <= q32;
              freq_r  <= 1'b0;
              bump_r  <= 1'b0;
              state_r <= S_SPLIT;
            end
          end
        end
        S_DIV_C: begin
          if (div_done) begin
            res_cmp_r <= q32[15:0];
            res_och_r <= chan_r;
            state_r   <= S_DONE;
          end
        end
        S_SPLIT: begin
          if (tot_r == 32'd0) begin
            res_st_r <= tprc_pkg::ST_ZERO;
            state_r  <= S_DONE;
          end else if (tot_r <= tprc_pkg::RELOAD_SPAN) begin
            res_arr_r <= tot_dec[15:0];
            reload_r  <= tot_dec[15:0];
            state_r   <= S_DONE;
          end else begin
            psc_r     <= {1'b0, split_p};
            div_req_r <= '{start: 1'b1, wide: 1'b0, dividend: {32'd0, tot_r},
                           divisor: {15'd0, split_div}};
            state_r   <= S_DIV_R;
          end
        end
        S_DIV_R: begin
          if (div_done) begin
            if (freq_r && !bump_r && r_bad) begin
              // bump the prescaler once and divide again
              psc_r     <= psc_r + 17'd1;
              bump_r    <= 1'b1;
              div_req_r <= '{start: 1'b1, wide: 1'b0, dividend: {32'd0, tot_r},
                             divisor: {15'd0, psc_r + 17'd2}};
            end else if (psc_r[16] || r_bad) begin
              res_st_r <= tprc_pkg::ST_RANGE;
              state_r  <= S_DONE;
            end else begin
              res_psc_r <= psc_r[15:0];
              res_arr_r <= q32_dec[15:0];
              reload_r  <= q32_dec[15:0];
              state_r   <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_psc_r   <= res_psc_r;
            out_arr_r   <= res_arr_r;
            out_cmp_r   <= res_cmp_r;
            out_och_r   <= res_och_r;
            out_st_r    <= res_st_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.prescaler   = out_psc_r;
  assign out_ch.reload      = out_arr_r;
  assign out_ch.compare     = out_cmp_r;
  assign out_ch.out_channel = out_och_r;
  assign out_ch.status      = out_st_r;

  a_one_word_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("new word taken while one is in flight");

  a_error_clears_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != tprc_pkg::ST_OK) |->
      (out_ch.prescaler == 16'd0 && out_ch.reload == 16'd0 && out_ch.compare == 16'd0))
    else $error("error result carries nonzero fields");

  a_duty_no_split: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.compare != 16'd0) |->
      (out_ch.prescaler == 16'd0 && out_ch.reload == 16'd0))
    else $error("compare result carries prescaler or reload");

  a_reload_update: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(reload_r)) |->
      ($past(state_r) == S_SPLIT || $past(state_r) == S_DIV_R))
    else $error("stored reload changed outside a split");

endmodule
